/* src/assert_macros.svh */
// Assertion macros for the file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PPI_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pressure profile interpolator assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PPI_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pressure profile interpolator assertion failed");

`endif

/* src/ppi_pkg.sv */
// Package: constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package ppi_pkg;

   localparam int PROFILE_POINTS = 8;
   localparam int TIME_BITS      = 24;
   localparam int IDX_W          = $clog2(PROFILE_POINTS);
   localparam int P_W            = 16;
   localparam int PROD_W         = P_W + TIME_BITS;
   localparam int DCNT_W         = $clog2(PROD_W);
   localparam int AP_W           = 4;
   localparam int IN_IDX_W       = 3;
   localparam int IN_TIME_W      = 24;
   localparam int KIND_W         = 2;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [KIND_W-1:0] SEG_BEFORE = 2'd0;
   localparam logic [KIND_W-1:0] SEG_RAMP   = 2'd1;
   localparam logic [KIND_W-1:0] SEG_HOLD   = 2'd2;

   typedef struct packed {
      logic capture;
      logic wr_table;
      logic rd_issue;
      logic chk_step;
      logic setup;
      logic mul;
      logic div_step;
      logic fin_ramp;
      logic fin_last;
      logic fin_ack;
      logic out_load;
   } ppi_cmd_type;

   typedef struct packed {
      logic is_write;
      logic found;
      logic at_last;
      logic div_last;
   } ppi_stat_type;

endpackage
`default_nettype wire

/* src/ppi_dp.sv */
// Datapath: breakpoint table, segment search registers, multiplier and serial divider.
`timescale 1ns / 1ps
`default_nettype none
module ppi_dp
   import ppi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [AP_W-1:0]      csr_wr_data,
   input  wire logic                 req_func,
   input  wire logic [IN_IDX_W-1:0]  req_point_index,
   input  wire logic [IN_TIME_W-1:0] req_point_time,
   input  wire logic [P_W-1:0]       req_point_pressure,
   input  wire logic [IN_TIME_W-1:0] req_query_time,
   input  wire ppi_cmd_type          cmd,
   output ppi_stat_type              stat,
   output logic [P_W-1:0]            rsp_setpoint,
   output logic [KIND_W-1:0]         rsp_segment_kind
);

   logic [AP_W-1:0]       ap_ff;
   logic                  func_ff;
   logic [IN_IDX_W-1:0]   pidx_ff;
   logic [TIME_BITS-1:0]  ptime_ff;
   logic [P_W-1:0]        ppres_ff;
   logic [TIME_BITS-1:0]  qt_ff;

   logic [TIME_BITS-1:0]  t_mem [PROFILE_POINTS];
   logic [P_W-1:0]        p_mem [PROFILE_POINTS];
   logic [PROFILE_POINTS-1:0] vld_ff;
   logic [TIME_BITS-1:0]  rd_t_ff;
   logic [P_W-1:0]        rd_p_ff;
   logic                  rd_v_ff;

   logic [IDX_W-1:0]      idx_ff;
   logic [TIME_BITS-1:0]  prev_t_ff;
   logic [P_W-1:0]        prev_p_ff;

   logic [TIME_BITS-1:0]  dt_ff;
   logic [TIME_BITS-1:0]  offm_ff;
   logic [P_W-1:0]        dpm_ff;
   logic [P_W-1:0]        p1_ff;
   logic                  neg_ff;

   logic [PROD_W-1:0]     dvd_ff;
   logic [TIME_BITS-1:0]  rem_ff;
   logic [DCNT_W-1:0]     cnt_ff;

   logic [P_W-1:0]        res_val_ff;
   logic [KIND_W-1:0]     res_kind_ff;
   logic [P_W-1:0]        out_val_ff;
   logic [KIND_W-1:0]     out_kind_ff;

   logic [TIME_BITS-1:0]  cur_t;
   logic [P_W-1:0]        cur_p;
   logic [IDX_W-1:0]      last_idx;
   logic [IDX_W-1:0]      waddr;
   logic                  waddr_ok;
   logic [PROD_W-1:0]     prod_c;
   logic [TIME_BITS:0]    shifted;
   logic                  ge;
   logic [P_W:0]          ramp_sum;
   logic [P_W-1:0]        ramp_val;

   // An entry never written reads as the reset value of zero.
   assign cur_t = rd_v_ff ? rd_t_ff : '0;
   assign cur_p = rd_v_ff ? rd_p_ff : '0;

   always_comb begin
      int unsigned n_c;
      n_c = 32'(ap_ff);
      if (n_c == 0) begin
         n_c = 1;
      end
      if (n_c > PROFILE_POINTS) begin
         n_c = PROFILE_POINTS;
      end
      last_idx = IDX_W'(n_c - 1);
   end

   assign waddr    = IDX_W'(pidx_ff);
   assign waddr_ok = 32'(pidx_ff) < 32'(PROFILE_POINTS);

   assign prod_c  = PROD_W'(dpm_ff) * PROD_W'(offm_ff);
   assign shifted = {rem_ff, dvd_ff[PROD_W-1]};
   assign ge      = shifted >= {1'b0, dt_ff};

   // The quotient never exceeds the pressure step, so it fits the low bits.
   always_comb begin
      if (neg_ff) begin
         ramp_sum = {1'b0, p1_ff} - {1'b0, dvd_ff[P_W-1:0]};
         ramp_val = ramp_sum[P_W] ? '0 : ramp_sum[P_W-1:0];
      end else begin
         ramp_sum = {1'b0, p1_ff} + {1'b0, dvd_ff[P_W-1:0]};
         ramp_val = ramp_sum[P_W] ? '1 : ramp_sum[P_W-1:0];
      end
   end

   assign stat.is_write = func_ff == FUNC_WRITE;
   assign stat.found    = (idx_ff != '0) && (qt_ff >= prev_t_ff) && (qt_ff < cur_t);
   assign stat.at_last  = idx_ff == last_idx;
   assign stat.div_last = cnt_ff == '0;

   assign rsp_setpoint     = out_val_ff;
   assign rsp_segment_kind = out_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ap_ff  <= AP_W'(1);
         vld_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            ap_ff <= csr_wr_data;
         end
         if (cmd.wr_table && waddr_ok) begin
            vld_ff[waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_table && waddr_ok) begin
         t_mem[waddr] <= ptime_ff;
         p_mem[waddr] <= ppres_ff;
      end
      if (cmd.rd_issue) begin
         rd_t_ff <= t_mem[idx_ff];
         rd_p_ff <= p_mem[idx_ff];
         rd_v_ff <= vld_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         pidx_ff  <= req_point_index;
         ptime_ff <= TIME_BITS'(req_point_time);
         ppres_ff <= req_point_pressure;
         qt_ff    <= TIME_BITS'(req_query_time);
         idx_ff   <= '0;
      end
      if (cmd.chk_step) begin
         idx_ff    <= idx_ff + IDX_W'(1);
         prev_t_ff <= cur_t;
         prev_p_ff <= cur_p;
      end
      if (cmd.setup) begin
         dt_ff   <= cur_t - prev_t_ff;
         offm_ff <= cur_t - qt_ff;
         neg_ff  <= cur_p > prev_p_ff;
         dpm_ff  <= (cur_p > prev_p_ff) ? cur_p - prev_p_ff : prev_p_ff - cur_p;
         p1_ff   <= cur_p;
      end
      if (cmd.mul) begin
         dvd_ff <= prod_c;
         rem_ff <= '0;
         cnt_ff <= DCNT_W'(PROD_W - 1);
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? TIME_BITS'(shifted - {1'b0, dt_ff}) : shifted[TIME_BITS-1:0];
         dvd_ff <= {dvd_ff[PROD_W-2:0], ge};
         cnt_ff <= cnt_ff - DCNT_W'(1);
      end
      if (cmd.fin_ramp) begin
         res_val_ff  <= ramp_val;
         res_kind_ff <= SEG_RAMP;
      end
      if (cmd.fin_last) begin
         if (qt_ff >= cur_t) begin
            res_val_ff  <= cur_p;
            res_kind_ff <= SEG_HOLD;
         end else begin
            res_val_ff  <= '0;
            res_kind_ff <= SEG_BEFORE;
         end
      end
      if (cmd.fin_ack) begin
         res_val_ff  <= '0;
         res_kind_ff <= SEG_BEFORE;
      end
      if (cmd.out_load) begin
         out_val_ff  <= res_val_ff;
         out_kind_ff <= res_kind_ff;
      end
   end

endmodule
`default_nettype wire

/* src/ppi_ctrl.sv */
// Controller: state machine sequencing the search, multiply, divide and output load.
`timescale 1ns / 1ps
`default_nettype none
module ppi_ctrl
   import ppi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire ppi_stat_type stat,
   output ppi_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_WR   = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_CHK  = 3'd3;
   localparam logic [2:0] S_MUL  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;
   localparam logic [2:0] S_OUT  = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_WR;
            end
         end
         S_WR: begin
            // The captured function code decides between a table write and a search.
            if (stat.is_write) begin
               cmd.wr_table = 1'b1;
               cmd.fin_ack  = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.rd_issue = 1'b1;
               state_in     = S_CHK;
            end
         end
         S_RD: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_CHK;
         end
         S_CHK: begin
            if (stat.found) begin
               cmd.setup = 1'b1;
               state_in  = S_MUL;
            end else if (stat.at_last) begin
               cmd.fin_last = 1'b1;
               state_in     = S_OUT;
            end else begin
               cmd.chk_step = 1'b1;
               state_in     = S_RD;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.fin_ramp = 1'b1;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

/* src/pressure_profile_interpolator_core.sv */
// Pressure profile interpolator: breakpoint table with piecewise-linear setpoint lookup.
// Usage: the request channel (req_valid/req_ready) carries one item per transfer.
// With req_func low the item stores one (time, pressure) breakpoint in slot
// req_point_index; with req_func high it asks for the setpoint at req_query_time.
// Every item gives exactly one transfer on the response channel (rsp_valid/rsp_ready):
// a write gives setpoint 0 with kind 0, a query the interpolated or held pressure, or 0.
// csr_wr_en writes the number of active breakpoints; write it only while idle.
// Sequence: a write stores the breakpoint and then loads the output register. A query
// scans the table slot by slot, reading each slot and then checking it; a scan that
// stops without a ramp loads the hold or zero result, and a ramp found at a slot adds a
// multiply, 40 divider steps and a finish step before the output register is loaded.
// One item is in work at a time, as the controller takes no request until it is idle
// again, so req_ready returns in the cycle after the result is loaded.
// A finished response sits in the output register; the next request is taken while
// it waits, but a further result is held back until the receiver takes the first.
// Reset clears the table to zero, sets one active point and empties the output.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pressure_profile_interpolator_core
   import ppi_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [AP_W-1:0]      csr_wr_data,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_func,
   input  wire logic [IN_IDX_W-1:0]  req_point_index,
   input  wire logic [IN_TIME_W-1:0] req_point_time,
   input  wire logic [P_W-1:0]       req_point_pressure,
   input  wire logic [IN_TIME_W-1:0] req_query_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [P_W-1:0]            rsp_setpoint,
   output logic [KIND_W-1:0]         rsp_segment_kind
);

   ppi_cmd_type  cmd;
   ppi_stat_type stat;

   ppi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppi_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_func           (req_func),
      .req_point_index    (req_point_index),
      .req_point_time     (req_point_time),
      .req_point_pressure (req_point_pressure),
      .req_query_time     (req_query_time),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_setpoint       (rsp_setpoint),
      .rsp_segment_kind   (rsp_segment_kind)
   );

   // Only one item is in work, so a transfer in closes the request side.
   `PPI_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
   // A result never overwrites one the receiver has not yet taken.
   `PPI_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !rsp_valid || rsp_ready)
   // Write acknowledgements and times before the profile carry a zero setpoint.
   `PPI_ASSERT_IMPL(a_before_zero, rsp_valid && rsp_segment_kind == SEG_BEFORE,
                    rsp_setpoint == '0)

endmodule
`default_nettype wire
